// ===== sv/gbn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

    localparam int SEQ_W        = 16;
    localparam int HS_W         = SEQ_W + 1;
    localparam int WIN_W        = 6;
    localparam int CNT_W        = 6;
    localparam int CWND_CAP     = 32;
    // The cap is clamped to 32, which fits in the six-bit window register.
    localparam int WIN_LIMIT    = (CWND_CAP < 32) ? CWND_CAP : 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam logic [WIN_W-1:0] THRESH_RESET = 6'd16;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL  = 1'b0,
        CFG_THRESH = 1'b1
    } cfg_idx_t;

    // One unit of work for the back end: a run of segments and/or a fin.
    typedef struct packed {
        logic [SEQ_W-1:0] start;
        logic [CNT_W-1:0] count;
        logic [HS_W-1:0]  highest;
        logic [WIN_W-1:0] seg_win;
        logic             fin;
        logic [WIN_W-1:0] fin_win;
    } job_t;

endpackage
`default_nettype wire

// ===== sv/go_back_n_sender_congestion_window_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Go-back-N sender with a slow start congestion window. Each input
// transaction carries a command in s_tuser (send window, ack, timeout) and
// an ack number in s_tdata. A front end updates the window, threshold, ack
// count and high-water mark in the cycle the command is taken, and hands each
// send or fin to a four-entry job queue. A back end expands a job into results
// at one per cycle unless m_tready stalls the output: a send window command
// yields up to one window of segments (at most 32), followed
// by a fin result once every segment is acked; after fin every command is
// dropped. The queue lets the input keep flowing while results are stalled;
// the input stalls only when four jobs are waiting. Configuration writes must
// only be issued while no results are pending.
module go_back_n_sender_congestion_window_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // [15:0] ack_number
    input  wire logic [1:0]                      s_tuser,   // [1:0] command
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [23:0]                          m_tdata,   // [15:0] seq_number, [21:16] window_now
    output logic [1:0]                           m_tuser,   // [0] is_resend, [1] is_fin
    output logic                                 m_tlast
);
    import gbn_pkg::*;

    job_t push_data;
    job_t pop_data;
    logic push;
    logic pop;
    logic full;
    logic empty;

    gbn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (s_tvalid),
        .item_cmd   (s_tuser),
        .item_ack   (s_tdata),
        .queue_full (full),
        .item_ready (s_tready),
        .job_push   (push),
        .job_data   (push_data)
    );

    gbn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    gbn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (empty),
        .queue_data  (pop_data),
        .queue_pop   (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

// ===== sv/gbn_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbn_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  gbn_pkg::job_t      push_data,
    output logic               full,
    input  wire logic          pop,
    output gbn_pkg::job_t      pop_data,
    output logic               empty
);
    import gbn_pkg::*;

    job_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign full     = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill count and the pointers must agree.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue pop did not drain an entry");

endmodule
`default_nettype wire

// ===== sv/gbn_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbn_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          item_valid,
    input  wire logic [1:0]                    item_cmd,
    input  wire logic [gbn_pkg::SEQ_W-1:0]     item_ack,
    input  wire logic                          queue_full,
    output logic                               item_ready,
    output logic                               job_push,
    output gbn_pkg::job_t                      job_data
);
    import gbn_pkg::*;

    logic [SEQ_W-1:0] total_reg, total_next;
    logic [SEQ_W-1:0] acked_reg, acked_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic [WIN_W-1:0] thr_reg, thr_next;
    logic [WIN_W-1:0] prev_reg, prev_next;
    logic [HS_W-1:0]  hs_reg, hs_next;
    logic             done_reg, done_next;

    cmd_t             cmd;
    logic             accept;
    logic [HS_W-1:0]  top;
    logic [HS_W-1:0]  last;
    logic [HS_W-1:0]  start;
    logic [HS_W-1:0]  span;
    logic [WIN_W:0]   grow;
    logic [WIN_W-1:0] half;
    logic             fin_now;

    assign cmd        = cmd_t'(item_cmd);
    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        top   = {1'b0, acked_reg} + HS_W'(win_reg);
        last  = (top < {1'b0, total_reg}) ? top : {1'b0, total_reg};
        start = {1'b0, acked_reg} + 1'b1;
        span  = (last >= start) ? (last - {1'b0, acked_reg}) : '0;
        grow  = (win_reg < thr_reg) ? {win_reg, 1'b0} : ({1'b0, win_reg} + 1'b1);
        half  = prev_reg >> 1;

        total_next = total_reg;
        acked_next = acked_reg;
        win_next   = win_reg;
        thr_next   = thr_reg;
        prev_next  = prev_reg;
        hs_next    = hs_reg;
        done_next  = done_reg;
        fin_now    = 1'b0;
        job_push   = 1'b0;

        job_data.start   = start[SEQ_W-1:0];
        job_data.count   = '0;
        job_data.highest = hs_reg;
        job_data.seg_win = win_reg;
        job_data.fin     = 1'b0;
        job_data.fin_win = win_reg;

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TOTAL:  total_next = cfg_data[SEQ_W-1:0];
                CFG_THRESH: thr_next   = cfg_data[WIN_W-1:0];
                default:    total_next = total_reg;
            endcase
        end

        if (accept && !done_reg && cmd != CMD_NONE)
        begin
            unique case (cmd)
                CMD_SEND:
                begin
                    job_data.count = span[CNT_W-1:0];
                    if (top > hs_reg)
                    begin
                        hs_next = top;
                    end
                    prev_next = win_reg;
                    win_next  = (grow > (WIN_W+1)'(WIN_LIMIT)) ? WIN_W'(WIN_LIMIT)
                                                               : grow[WIN_W-1:0];
                end
                CMD_ACK:
                begin
                    if ({1'b0, item_ack} == start)
                    begin
                        acked_next = item_ack;
                    end
                end
                CMD_TIMEOUT:
                begin
                    thr_next = (half > WIN_W'(1)) ? half : WIN_W'(1);
                    win_next = WIN_W'(1);
                end
                default:
                begin
                    win_next = win_reg;
                end
            endcase

            fin_now          = (acked_next >= total_reg);
            done_next        = fin_now;
            job_data.fin     = fin_now;
            job_data.fin_win = win_next;
            job_push         = fin_now || (job_data.count != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            acked_reg <= '0;
            win_reg   <= WIN_W'(1);
            thr_reg   <= THRESH_RESET;
            prev_reg  <= WIN_W'(1);
            hs_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            acked_reg <= acked_next;
            win_reg   <= win_next;
            thr_reg   <= thr_next;
            prev_reg  <= prev_next;
            hs_reg    <= hs_next;
            done_reg  <= done_next;
        end
    end

    a_win_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (win_reg != '0) && (win_reg <= WIN_W'(WIN_LIMIT)))
        else $error("window out of range");
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg && $stable(acked_reg))
        else $error("state moved after fin");
    a_job_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job_data.count <= CNT_W'(WIN_LIMIT)))
        else $error("run longer than the window cap");

endmodule
`default_nettype wire

// ===== sv/gbn_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbn_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      queue_empty,
    input  gbn_pkg::job_t                  queue_data,
    output logic                           queue_pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [23:0]                    m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import gbn_pkg::*;

    job_t             cur_reg, cur_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] off_reg, off_next;
    logic             valid_reg, valid_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             resend_reg, resend_next;
    logic             fin_reg, fin_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic             last_reg, last_next;

    logic             load_out;
    logic             emit;
    logic             is_seg;
    logic             finish;
    logic [SEQ_W-1:0] seq_now;

    assign load_out = !valid_reg || m_tready;
    assign emit     = busy_reg && load_out;
    assign is_seg   = off_reg < cur_reg.count;
    assign seq_now  = cur_reg.start + SEQ_W'(off_reg);
    // The last segment closes the job unless a fin follows it.
    assign finish   = is_seg ? ((off_reg + 1'b1 == cur_reg.count) && !cur_reg.fin) : 1'b1;
    assign queue_pop = (!busy_reg || (emit && finish)) && !queue_empty;

    always_comb
    begin
        cur_next    = cur_reg;
        busy_next   = busy_reg;
        off_next    = off_reg;
        valid_next  = valid_reg && !m_tready;
        seq_next    = seq_reg;
        resend_next = resend_reg;
        fin_next    = fin_reg;
        win_next    = win_reg;
        last_next   = last_reg;

        if (emit)
        begin
            valid_next = 1'b1;
            if (is_seg)
            begin
                seq_next    = seq_now;
                resend_next = ({1'b0, seq_now} <= cur_reg.highest);
                fin_next    = 1'b0;
                win_next    = cur_reg.seg_win;
            end
            else
            begin
                seq_next    = '0;
                resend_next = 1'b0;
                fin_next    = 1'b1;
                win_next    = cur_reg.fin_win;
            end
            last_next = finish;
            off_next  = finish ? '0 : off_reg + 1'b1;
            if (finish)
            begin
                busy_next = 1'b0;
            end
        end

        if (queue_pop)
        begin
            cur_next  = queue_data;
            busy_next = 1'b1;
            off_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        seq_reg    <= seq_next;
        resend_reg <= resend_next;
        fin_reg    <= fin_next;
        win_reg    <= win_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            off_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            off_reg   <= off_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, win_reg, seq_reg};
    assign m_tuser  = {fin_reg, resend_reg};
    assign m_tlast  = last_reg;

    a_fin_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && fin_reg) |-> (last_reg && seq_reg == '0 && !resend_reg))
        else $error("fin result malformed");
    a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (off_reg <= cur_reg.count))
        else $error("run offset past job length");
    a_win_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (win_reg != '0))
        else $error("result carries an empty window");

endmodule
`default_nettype wire
